// ----- hdl/tmdf_pkg.sv -----
// Shared types, widths and register codes of the trimmed mean distance filter.
`timescale 1ns / 1ps

package tmdf_pkg;

    localparam int MS_W           = 32;
    localparam int DIST_W         = 14;
    localparam int INTERVAL_W     = 16;
    localparam int WLEN_W         = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [DIST_W-1:0]     MAX_DIST_RST = 14'd6400;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd100;
    localparam logic [WLEN_W-1:0]     WLEN_RST     = 5'd10;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WLEN     = 2'd2;

    typedef struct packed {
        logic [MS_W-1:0]   now_ms;
        logic [DIST_W-1:0] sample_q4;
        logic              sample_valid;
    } in_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance_q4;
        logic              ready_res;
        logic              recorded;
    } out_word_t;

endpackage

// ----- hdl/trimmed_mean_distance_filter.sv -----
// Top level of the trimmed mean distance filter.
`timescale 1ns / 1ps
//
// Input channel (in_valid / in_stall) carries one word per measurement: the
// millisecond time, a Q10.4 distance and its valid flag. Every input word gives
// exactly one output word (out_valid / out_stall): the trimmed ring mean, the
// ring-full flag and whether the sample was stored. The configuration channel
// (cfg_valid / cfg_ready, always ready) writes max distance, interval and
// window length; write it only while no word is in flight.
// One word is worked on at a time; in_stall is high from acceptance until the
// result is handed to the output register. Once the ring is full, the ring
// memory is read one entry a cycle over the effective window, then the
// restoring divider gives one quotient bit a cycle. Before the ring is full,
// the walk and the division are skipped. The next word can be accepted in the
// cycle after a result enters the output register.
// The output register holds a result while out_stall is high; the next input
// word is still accepted and waits in the last step until the register frees.
// Reset clears the ring (per-entry valid bits), write index, recording time,
// ring-full flag and registers to their defaults; no clearing pass is needed.

module trimmed_mean_distance_filter #(
    parameter int MAX_WINDOW = tmdf_pkg::MAX_WINDOW_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  tmdf_pkg::in_word_t               in_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output tmdf_pkg::out_word_t              out_word,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tmdf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tmdf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import tmdf_pkg::*;

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
    localparam int SUM_W = DIST_W + CNT_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RECORD = 7'b0000010,
        S_WALK   = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_PREP   = 7'b0010000,
        S_DIVIDE = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [DIST_W-1:0]     max_dist_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [WLEN_W-1:0]     wlen_reg;

    in_word_t          item_reg;
    logic [MS_W-1:0]   last_ms_reg;
    logic [IDX_W-1:0]  write_idx_reg;
    logic              filled_reg;
    logic              rec_reg;

    logic [DIST_W-1:0] mem_reg [MAX_WINDOW];
    logic              entry_vld_reg [MAX_WINDOW];
    logic [DIST_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    logic [CNT_W-1:0]  walk_idx_reg;
    logic              acc_en_reg;
    logic              first_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [DIST_W-1:0] lo_reg;
    logic [DIST_W-1:0] hi_reg;

    out_word_t         out_word_reg;
    logic              out_valid_reg;

    logic [LEN_W-1:0]  wlen_ext;
    logic [CNT_W-1:0]  eff_n;
    logic [MS_W-1:0]   elapsed;
    logic              rec_hit;
    logic [DIST_W-1:0] rec_value;
    logic [CNT_W-1:0]  idx_inc;
    logic              wrap;
    logic [DIST_W-1:0] entry_val;
    logic              trim;
    logic [SUM_W-1:0]  dividend;
    logic [CNT_W:0]    divisor_wide;
    logic [CNT_W-1:0]  divisor;
    logic              div_start;
    logic              div_done;
    logic [SUM_W-1:0]  quotient;
    logic              out_free;

    always_comb
    begin
        wlen_ext = LEN_W'(wlen_reg);
        if (wlen_ext == '0)
            eff_n = CNT_W'(1);
        else if (wlen_ext > LEN_W'(MAX_WINDOW))
            eff_n = CNT_W'(MAX_WINDOW);
        else
            eff_n = wlen_ext[CNT_W-1:0];
    end

    assign elapsed   = item_reg.now_ms - last_ms_reg;
    assign rec_hit   = elapsed > MS_W'(interval_reg);
    assign rec_value = item_reg.sample_valid ? item_reg.sample_q4 : max_dist_reg;
    assign idx_inc   = CNT_W'(write_idx_reg) + CNT_W'(1);
    assign wrap      = !(idx_inc < eff_n);
    assign entry_val = rd_vld_reg ? rd_data_reg : '0;
    assign out_free  = !out_valid_reg || !out_stall;

    assign trim         = {1'b0, eff_n} > (CNT_W+1)'(2);
    assign divisor_wide = trim ? ({1'b0, eff_n} - (CNT_W+1)'(2)) : {1'b0, eff_n};
    assign divisor      = divisor_wide[CNT_W-1:0];
    assign dividend     = trim ? (sum_reg - SUM_W'(lo_reg) - SUM_W'(hi_reg)) : sum_reg;
    assign div_start    = (state_reg == S_PREP);

    tmdf_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= MAX_DIST_RST;
            interval_reg <= INTERVAL_RST;
            wlen_reg     <= WLEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MAX_DIST: max_dist_reg <= cfg_data[DIST_W-1:0];
                REG_INTERVAL: interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_WLEN:     wlen_reg     <= cfg_data[WLEN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_RECORD;
            S_RECORD: state_next = (filled_reg || (rec_hit && wrap)) ? S_WALK : S_DONE;
            S_WALK:   if (walk_idx_reg + CNT_W'(1) == eff_n) state_next = S_DRAIN;
            S_DRAIN:  state_next = S_PREP;
            S_PREP:   state_next = S_DIVIDE;
            S_DIVIDE: if (div_done) state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

    // hold the accepted word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            item_reg <= in_word;
    end

    // record stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_ms_reg   <= '0;
            write_idx_reg <= '0;
            filled_reg    <= 1'b0;
            rec_reg       <= 1'b0;
        end
        else if (state_reg == S_RECORD)
        begin
            rec_reg <= rec_hit;
            if (rec_hit)
            begin
                last_ms_reg <= item_reg.now_ms;
                if (wrap)
                begin
                    write_idx_reg <= '0;
                    filled_reg    <= 1'b1;
                end
                else
                begin
                    write_idx_reg <= idx_inc[IDX_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WINDOW; i++)
                entry_vld_reg[i] <= 1'b0;
        end
        else if (state_reg == S_RECORD && rec_hit)
        begin
            entry_vld_reg[write_idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RECORD && rec_hit)
            mem_reg[write_idx_reg] <= rec_value;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[walk_idx_reg[IDX_W-1:0]];
    end

    // walk the ring, accumulate sum, minimum and maximum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            walk_idx_reg <= '0;
            acc_en_reg   <= 1'b0;
            first_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= entry_vld_reg[walk_idx_reg[IDX_W-1:0]];
            acc_en_reg <= (state_reg == S_WALK);
            if (state_reg == S_RECORD)
            begin
                walk_idx_reg <= '0;
                first_reg    <= 1'b1;
            end
            else
            begin
                if (state_reg == S_WALK)
                    walk_idx_reg <= walk_idx_reg + CNT_W'(1);
                if (acc_en_reg)
                    first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_en_reg)
        begin
            if (first_reg)
            begin
                sum_reg <= SUM_W'(entry_val);
                lo_reg  <= entry_val;
                hi_reg  <= entry_val;
            end
            else
            begin
                sum_reg <= sum_reg + SUM_W'(entry_val);
                if (entry_val < lo_reg)
                    lo_reg <= entry_val;
                if (entry_val > hi_reg)
                    hi_reg <= entry_val;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            out_word_reg.distance_q4 <= filled_reg ? quotient[DIST_W-1:0] : '0;
            out_word_reg.ready_res   <= filled_reg;
            out_word_reg.recorded    <= rec_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_filled_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg |=> filled_reg)
        else $error("ring-full flag dropped");

    a_not_ready_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_word_reg.ready_res |-> out_word_reg.distance_q4 == '0)
        else $error("distance reported before ring full");

    a_record_time: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RECORD) && rec_hit |=> last_ms_reg == $past(item_reg.now_ms))
        else $error("recording time not updated");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIVIDE)
        else $error("divider finished outside divide step");

endmodule

// ----- hdl/tmdf_div.sv -----
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module tmdf_div #(
    parameter int DVD_W = 19,
    parameter int DVS_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    rem_shift;
    logic [DVS_W+1:0]  diff;
    logic              ge;

    assign rem_shift = {rem_reg, quo_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign ge        = ~diff[DVS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DVD_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- tb/sv/tb_trimmed_mean_distance_filter.sv -----
// Self-checking testbench of the trimmed mean distance filter with its own predictor.
`timescale 1ns / 1ps

module tb_trimmed_mean_distance_filter;
    import tmdf_pkg::*;

    localparam int RING_DEPTH   = 16;
    localparam int SETTLE_CYCLES = RING_DEPTH + 14 + 5 + 5 + 8;
    localparam int RANDOM_ITEMS = 1400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_word_t in_word = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_word_t out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    trimmed_mean_distance_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predictor state and register copies
    logic [DIST_W-1:0]     max_dist_reg = MAX_DIST_RST;
    logic [INTERVAL_W-1:0] interval_reg = INTERVAL_RST;
    logic [WLEN_W-1:0]     wlen_reg     = WLEN_RST;
    logic [DIST_W-1:0]     distance_ring [RING_DEPTH];
    int unsigned           ring_wr_idx  = 0;
    logic [MS_W-1:0]       last_rec_ms  = '0;
    logic                  ring_full    = 1'b0;

    out_word_t filtered_words [$];
    int error_count = 0;
    int burst_left = 0;
    int stall_cycle = 0;

    initial
    begin
        for (int i = 0; i < RING_DEPTH; i++)
            distance_ring[i] = '0;
    end

    function automatic out_word_t filter_reading(input in_word_t w);
        out_word_t r;
        logic [MS_W-1:0] elapsed;
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned total;
        r = '0;
        n = (wlen_reg == 0) ? 1 : ((wlen_reg > RING_DEPTH) ? RING_DEPTH : wlen_reg);
        elapsed = w.now_ms - last_rec_ms;
        if (elapsed > MS_W'(interval_reg))
        begin
            if (ring_wr_idx < RING_DEPTH)
                distance_ring[ring_wr_idx] = w.sample_valid ? w.sample_q4 : max_dist_reg;
            if (ring_wr_idx + 1 < n)
                ring_wr_idx++;
            else
            begin
                ring_wr_idx = 0;
                ring_full = 1'b1;
            end
            last_rec_ms = w.now_ms;
            r.recorded = 1'b1;
        end
        if (ring_full)
        begin
            lo = distance_ring[0];
            hi = distance_ring[0];
            total = distance_ring[0];
            for (int k = 1; k < n; k++)
            begin
                if (distance_ring[k] < lo)
                    lo = distance_ring[k];
                if (distance_ring[k] > hi)
                    hi = distance_ring[k];
                total += distance_ring[k];
            end
            if (n > 2)
                r.distance_q4 = DIST_W'((total - lo - hi) / (n - 2));
            else
                r.distance_q4 = DIST_W'(total / n);
        end
        r.ready_res = ring_full;
        return r;
    endfunction

    function automatic in_word_t reading(input logic [MS_W-1:0] t,
                                         input logic [DIST_W-1:0] d, input logic v);
        in_word_t w;
        w.now_ms = t;
        w.sample_q4 = d;
        w.sample_valid = v;
        return w;
    endfunction

    task automatic send_reading(input in_word_t w);
        @(negedge clk);
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        filtered_words.push_back(filter_reading(w));
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 40)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 12);
        end
    endtask

    // Drop valid and wait until every word has come out and the block is idle
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (filtered_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_MAX_DIST: max_dist_reg = d[DIST_W-1:0];
            REG_INTERVAL: interval_reg = d[INTERVAL_W-1:0];
            REG_WLEN:     wlen_reg = d[WLEN_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_registers();
        send_reading(reading(32'd0, 14'd5, 1'b1));
        send_reading(reading(32'd100, 14'd7, 1'b1));
        send_reading(reading(32'd101, 14'h3FFF, 1'b1));
        send_reading(reading(32'hFFFF_FFFF, 14'h1555, 1'b0));
        settle();
    endtask

    task automatic test_window_edges();
        // zero length acts as one; index past the end wraps and fills
        write_reg(REG_MAX_DIST, 16'h3FFF);
        write_reg(REG_INTERVAL, 16'd0);
        write_reg(REG_WLEN, 16'd0);
        send_reading(reading(32'hFFFF_FFFF, 14'h2AAA, 1'b1));
        send_reading(reading(32'd0, 14'd0, 1'b1));
        send_reading(reading(32'd1, 14'h2AAA, 1'b0));
        settle();
        write_reg(REG_WLEN, 16'd2);
        write_reg(REG_MAX_DIST, 16'd0);
        send_reading(reading(32'd2, 14'h3FFF, 1'b0));
        send_reading(reading(32'd3, 14'h3FFF, 1'b1));
        settle();
        write_reg(REG_WLEN, 16'd3);
        send_reading(reading(32'd4, 14'd100, 1'b1));
        send_reading(reading(32'd5, 14'd200, 1'b1));
        send_reading(reading(32'd6, 14'd300, 1'b0));
        settle();
        // above the ring depth clamps to the full ring
        write_reg(REG_WLEN, 16'hFFFF);
        send_reading(reading(32'd7, 14'h3FFF, 1'b1));
        send_reading(reading(32'd7, 14'h1234, 1'b1));
        settle();
    endtask

    task automatic test_long_interval();
        write_reg(REG_INTERVAL, 16'hFFFF);
        write_reg(REG_MAX_DIST, 16'hFFFF);
        write_reg(REG_WLEN, 16'd4);
        send_reading(reading(last_rec_ms + 32'd65535, 14'h0F0F, 1'b1));
        send_reading(reading(last_rec_ms + 32'd65536, 14'h30F0, 1'b0));
        settle();
    endtask

    task automatic randomise_registers();
        logic [CFG_DATA_W-1:0] d;
        d = $urandom;
        case ($urandom_range(0, 3))
            0: d[DIST_W-1:0] = '0;
            1: d[DIST_W-1:0] = '1;
            default: ;
        endcase
        write_reg(REG_MAX_DIST, d);
        case ($urandom_range(0, 5))
            0: d = '0;
            1: d = '1;
            2: d = $urandom;
            default: d = $urandom_range(0, 200);
        endcase
        write_reg(REG_INTERVAL, d);
        d = $urandom;
        case ($urandom_range(0, 9))
            0: d[WLEN_W-1:0] = 5'd0;
            1: d[WLEN_W-1:0] = 5'($urandom_range(17, 31));
            2: d[WLEN_W-1:0] = 5'd1;
            3: d[WLEN_W-1:0] = 5'd2;
            4: d[WLEN_W-1:0] = 5'd16;
            default: d[WLEN_W-1:0] = 5'($urandom_range(1, 16));
        endcase
        write_reg(REG_WLEN, d);
    endtask

    task automatic test_random_phases();
        int sent;
        int phase_len;
        logic [MS_W-1:0] gap_ms;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            randomise_registers();
            phase_len = $urandom_range(50, 160);
            for (int i = 0; i < phase_len; i++)
            begin
                case ($urandom_range(0, 11))
                    0: gap_ms = $urandom;
                    1: gap_ms = MS_W'(interval_reg);
                    2: gap_ms = $urandom_range(0, interval_reg);
                    default: gap_ms = MS_W'(interval_reg) + 1 + $urandom_range(0, 60);
                endcase
                send_reading(reading(last_rec_ms + gap_ms, DIST_W'($urandom),
                                     ($urandom_range(0, 4) != 0)));
            end
            sent += phase_len;
            settle();
        end
    endtask

    always @(negedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 300) % 4)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= stall_cycle[3] & stall_cycle[1];
        endcase
    end

    always @(posedge clk)
    begin : check_words
        out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (filtered_words.size() == 0)
            begin
                $display("%0t: output word %h with none expected", $time, out_word);
                error_count++;
            end
            else
            begin
                exp_w = filtered_words.pop_front();
                if (out_word.distance_q4 !== exp_w.distance_q4)
                begin
                    $display("%0t: distance_q4 expected %0d actual %0d",
                             $time, exp_w.distance_q4, out_word.distance_q4);
                    error_count++;
                end
                if (out_word.ready_res !== exp_w.ready_res)
                begin
                    $display("%0t: ready_res expected %0b actual %0b",
                             $time, exp_w.ready_res, out_word.ready_res);
                    error_count++;
                end
                if (out_word.recorded !== exp_w.recorded)
                begin
                    $display("%0t: recorded expected %0b actual %0b",
                             $time, exp_w.recorded, out_word.recorded);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_default_registers();
        test_window_edges();
        test_long_interval();
        test_random_phases();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tmdf_pkg.sv
hdl/tmdf_div.sv
hdl/trimmed_mean_distance_filter.sv
tb/sv/tb_trimmed_mean_distance_filter.sv
